### rtl/dcts_pkg.sv
// Package for the dual channel tone strength unit.
// Field widths, register indexes and reset values, queue sizing, and the
// quarter-wave sine function used to build the constant lookup table.
`timescale 1ns / 1ps
`default_nettype none

package dcts_pkg;

  localparam int unsigned SAMPLE_W   = 12;  // width of one ADC sample field
  localparam int unsigned PHASE_W    = 16;  // phase, fraction of a turn
  localparam int unsigned WIN_W      = 10;  // window length and pair count
  localparam int unsigned STRENGTH_W = 38;  // result field width
  localparam int unsigned SINE_W     = 16;  // signed Q1.15 table value

  localparam int unsigned IN_DATA_W  = 24;  // 2 x 12, already whole bytes
  localparam int unsigned OUT_DATA_W = 80;  // 2 x 38, padded to 10 bytes

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b1;

  localparam logic [PHASE_W-1:0] PHASE_STEP_RST    = 16'd13107;
  localparam logic [WIN_W-1:0]   WINDOW_LENGTH_RST = 10'd100;

  // Queue of finished accumulator sets between the accumulator and the
  // magnitude unit.
  localparam int unsigned ACC_FIFO_DEPTH = 4;
  localparam int unsigned ACC_FIFO_PTR_W = 2;
  localparam int unsigned ACC_FIFO_CNT_W = 3;

  typedef struct packed {
    logic [ACC_FIFO_CNT_W-1:0] count;
    logic                      empty;
  } fifo_status_t;

  // Sine of a quarter-table index r, Q1.15, clamped to 0..32767. Taylor
  // series in Q30 with seven correction terms. Used at elaboration only.
  function automatic logic [14:0] quarter_sine(input int unsigned r,
                                               input int unsigned abits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [64:0] sum;
    logic [63:0]        v;
    x    = (64'(r) * 64'd6746518852) >> abits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed({1'b0, x});
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - $signed({1'b0, term});
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + $signed({1'b0, term});
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - $signed({1'b0, term});
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + $signed({1'b0, term});
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - $signed({1'b0, term});
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + $signed({1'b0, term});
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - $signed({1'b0, term});
    if (sum < 0) begin
      sum = '0;
    end
    v = (sum[63:0] + 64'd16384) >> 15;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

endpackage

`default_nettype wire

### rtl/dcts_acc_fifo.sv
// Short queue of finished accumulator sets, register based.
// Depends on dcts_pkg for depth, pointer widths and the status struct.
`timescale 1ns / 1ps
`default_nettype none

module dcts_acc_fifo #(
  parameter int unsigned WIDTH = 156
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire logic [WIDTH-1:0]      push_data_i,
  input  wire logic                  pop_i,
  output logic [WIDTH-1:0]           pop_data_o,
  output dcts_pkg::fifo_status_t     status_o
);
  import dcts_pkg::*;

  logic [WIDTH-1:0]          mem_q [ACC_FIFO_DEPTH];
  logic [ACC_FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [ACC_FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [ACC_FIFO_CNT_W-1:0] count_q, count_d;
  logic                      do_push;
  logic                      do_pop;

  assign do_push = push_i && (count_q != ACC_FIFO_CNT_W'(ACC_FIFO_DEPTH));
  assign do_pop  = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o     = mem_q[rd_ptr_q];
  assign status_o.count = count_q;
  assign status_o.empty = (count_q == '0);

endmodule

`default_nettype wire

### rtl/dcts_front.sv
// Front part: configuration registers, phase and window tracking, table
// lookup and the four multiply-accumulate lanes. Depends on dcts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcts_front #(
  parameter int unsigned SAMPLE_BITS     = 12,
  parameter int unsigned TABLE_ADDR_BITS = 10,
  parameter int unsigned ACC_W           = 39
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dcts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [dcts_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [dcts_pkg::SAMPLE_W-1:0] sample_one_i,
  input  wire logic [dcts_pkg::SAMPLE_W-1:0] sample_two_i,
  input  wire dcts_pkg::fifo_status_t        fifo_status_i,
  output logic                               push_o,
  output logic [4*ACC_W-1:0]                 push_data_o
);
  import dcts_pkg::*;

  localparam int unsigned EFF_W  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int unsigned PROD_W = EFF_W + SINE_W + 1;
  localparam int unsigned TAB    = TABLE_ADDR_BITS;
  localparam int unsigned TA_W   = TAB - 1;
  localparam int unsigned QN     = 1 << (TAB - 2);
  localparam logic [TA_W-1:0] QN_A = TA_W'(QN);
  localparam logic [TAB-1:0]  QN_I = TAB'(QN);

  // Quarter-wave table, entries 0 to a quarter turn inclusive.
  logic [14:0] qtab [QN+1];

  for (genvar g = 0; g <= QN; g++) begin : g_qtab
    assign qtab[g] = quarter_sine(g, TAB);
  end

  // Mirror and sign of a full-turn index: {negate, quarter table address}.
  function automatic logic [TA_W:0] tbl_addr(input logic [TAB-1:0] idx);
    logic [TA_W-1:0] r;
    r = {1'b0, idx[TAB-3:0]};
    if (idx[TAB-2]) begin
      r = QN_A - r;
    end
    return {idx[TAB-1], r};
  endfunction

  logic [PHASE_W-1:0] phase_step_q;
  logic [WIN_W-1:0]   window_len_q;
  logic [PHASE_W-1:0] phase_q;
  logic [WIN_W-1:0]   count_q;

  logic               in_fire;
  logic [WIN_W-1:0]   count_inc;
  logic [WIN_W-1:0]   limit;
  logic               win_end;
  logic [TAB-1:0]     sin_idx;
  logic [TAB-1:0]     cos_idx;
  logic [TA_W:0]      sin_a;
  logic [TA_W:0]      cos_a;
  logic signed [SINE_W-1:0] sin_pos, cos_pos, sin_val, cos_val;
  logic [ACC_FIFO_CNT_W:0]  slots_used;

  // Stage A: samples and table values.
  logic                     a_valid_q, a_end_q;
  logic [EFF_W-1:0]         a_s1_q, a_s2_q;
  logic signed [SINE_W-1:0] a_sin_q, a_cos_q;

  // Stage B: products.
  logic                     b_valid_q, b_end_q;
  logic signed [PROD_W-1:0] b_p1s_q, b_p1c_q, b_p2s_q, b_p2c_q;

  // Stage C: accumulators.
  logic signed [ACC_W-1:0]  acc1s_q, acc1c_q, acc2s_q, acc2c_q;
  logic signed [ACC_W-1:0]  sum1s, sum1c, sum2s, sum2c;

  // Hold off input while every queue slot may be claimed by a window end
  // already in the pipeline.
  assign slots_used = {1'b0, fifo_status_i.count}
                    + (ACC_FIFO_CNT_W+1)'(a_valid_q && a_end_q)
                    + (ACC_FIFO_CNT_W+1)'(b_valid_q && b_end_q);
  assign in_ready_o = slots_used < (ACC_FIFO_CNT_W+1)'(ACC_FIFO_DEPTH);
  assign in_fire    = in_valid_i && in_ready_o;

  assign count_inc = count_q + 1'b1;
  assign limit     = (window_len_q == '0) ? WIN_W'(1) : window_len_q;
  assign win_end   = (count_inc == '0) || (count_inc >= limit);

  assign sin_idx = phase_q[PHASE_W-1 -: TAB];
  assign cos_idx = sin_idx + QN_I;
  assign sin_a   = tbl_addr(sin_idx);
  assign cos_a   = tbl_addr(cos_idx);
  assign sin_pos = $signed({1'b0, qtab[sin_a[TA_W-1:0]]});
  assign cos_pos = $signed({1'b0, qtab[cos_a[TA_W-1:0]]});
  assign sin_val = sin_a[TA_W] ? -sin_pos : sin_pos;
  assign cos_val = cos_a[TA_W] ? -cos_pos : cos_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= PHASE_STEP_RST;
      window_len_q <= WINDOW_LENGTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PHASE_STEP:    phase_step_q <= cfg_data_i[PHASE_W-1:0];
        REG_WINDOW_LENGTH: window_len_q <= cfg_data_i[WIN_W-1:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= '0;
      count_q   <= '0;
      a_valid_q <= 1'b0;
      a_end_q   <= 1'b0;
      b_valid_q <= 1'b0;
      b_end_q   <= 1'b0;
    end else begin
      if (in_fire) begin
        if (win_end) begin
          phase_q <= '0;
          count_q <= '0;
        end else begin
          phase_q <= phase_q + phase_step_q;
          count_q <= count_inc;
        end
      end
      a_valid_q <= in_fire;
      a_end_q   <= in_fire && win_end;
      b_valid_q <= a_valid_q;
      b_end_q   <= a_valid_q && a_end_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_s1_q  <= sample_one_i[EFF_W-1:0];
      a_s2_q  <= sample_two_i[EFF_W-1:0];
      a_sin_q <= sin_val;
      a_cos_q <= cos_val;
    end
    if (a_valid_q) begin
      b_p1s_q <= $signed({1'b0, a_s1_q}) * a_sin_q;
      b_p1c_q <= $signed({1'b0, a_s1_q}) * a_cos_q;
      b_p2s_q <= $signed({1'b0, a_s2_q}) * a_sin_q;
      b_p2c_q <= $signed({1'b0, a_s2_q}) * a_cos_q;
    end
  end

  assign sum1s = acc1s_q + {{(ACC_W-PROD_W){b_p1s_q[PROD_W-1]}}, b_p1s_q};
  assign sum1c = acc1c_q + {{(ACC_W-PROD_W){b_p1c_q[PROD_W-1]}}, b_p1c_q};
  assign sum2s = acc2s_q + {{(ACC_W-PROD_W){b_p2s_q[PROD_W-1]}}, b_p2s_q};
  assign sum2c = acc2c_q + {{(ACC_W-PROD_W){b_p2c_q[PROD_W-1]}}, b_p2c_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc1s_q <= '0;
      acc1c_q <= '0;
      acc2s_q <= '0;
      acc2c_q <= '0;
    end else if (b_valid_q) begin
      // Clear on the last pair of a window; its totals go to the queue.
      if (b_end_q) begin
        acc1s_q <= '0;
        acc1c_q <= '0;
        acc2s_q <= '0;
        acc2c_q <= '0;
      end else begin
        acc1s_q <= sum1s;
        acc1c_q <= sum1c;
        acc2s_q <= sum2s;
        acc2c_q <= sum2c;
      end
    end
  end

  assign push_o      = b_valid_q && b_end_q;
  assign push_data_o = {sum2c, sum2s, sum1c, sum1s};

endmodule

`default_nettype wire

### rtl/dcts_magnitude.sv
// Back part: takes one accumulator set from the queue, forms the sum of
// squares serially, takes its floor square root two bits a step, and holds
// the result in the output register. Depends on dcts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dcts_magnitude #(
  parameter int unsigned ACC_W = 39
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire dcts_pkg::fifo_status_t          fifo_status_i,
  input  wire logic [4*ACC_W-1:0]              pop_data_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [dcts_pkg::STRENGTH_W-1:0]      strength_one_o,
  output logic [dcts_pkg::STRENGTH_W-1:0]      strength_two_o
);
  import dcts_pkg::*;

  localparam int unsigned RAD_W  = 2 * ACC_W;
  localparam int unsigned REM_W  = ACC_W + 3;
  localparam int unsigned STEP_W = $clog2(ACC_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ACC_W - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SQUARE = 2'd1;
  localparam logic [1:0] ST_ROOT   = 2'd2;
  localparam logic [1:0] ST_WAIT   = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [ACC_W-1:0]  m1s_q, m1c_q, m2s_q, m2c_q;
  logic [RAD_W-1:0]  rad1_q, rad2_q, rad1_d, rad2_d;
  logic [REM_W-1:0]  rem1_q, rem2_q, rem1_d, rem2_d;
  logic [ACC_W-1:0]  root1_q, root2_q, root1_d, root2_d;
  logic              out_valid_q;
  logic [STRENGTH_W-1:0] str1_q, str2_q;
  logic              load_out;

  logic signed [ACC_W-1:0] a1s, a1c, a2s, a2c;
  logic [REM_W-1:0]  sh1, sh2, tr1, tr2;

  function automatic logic [ACC_W-1:0] abs_val(input logic signed [ACC_W-1:0] v);
    return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
  endfunction

  assign a1s = pop_data_i[0*ACC_W +: ACC_W];
  assign a1c = pop_data_i[1*ACC_W +: ACC_W];
  assign a2s = pop_data_i[2*ACC_W +: ACC_W];
  assign a2c = pop_data_i[3*ACC_W +: ACC_W];

  assign pop_o    = (state_q == ST_IDLE) && !fifo_status_i.empty;
  assign load_out = (state_q == ST_WAIT) && (!out_valid_q || out_ready_i);

  assign sh1 = {rem1_q[REM_W-3:0], rad1_q[RAD_W-1 -: 2]};
  assign sh2 = {rem2_q[REM_W-3:0], rad2_q[RAD_W-1 -: 2]};
  assign tr1 = REM_W'({root1_q, 2'b01});
  assign tr2 = REM_W'({root2_q, 2'b01});

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    rad1_d  = rad1_q;
    rad2_d  = rad2_q;
    rem1_d  = rem1_q;
    rem2_d  = rem2_q;
    root1_d = root1_q;
    root2_d = root2_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!fifo_status_i.empty) begin
          state_d = ST_SQUARE;
          step_d  = LAST_STEP;
          rad1_d  = '0;
          rad2_d  = '0;
        end
      end
      ST_SQUARE: begin
        // Horner form of s*s + c*c, one multiplier bit of each per step.
        rad1_d = {rad1_q[RAD_W-2:0], 1'b0}
               + (m1s_q[step_q] ? RAD_W'(m1s_q) : '0)
               + (m1c_q[step_q] ? RAD_W'(m1c_q) : '0);
        rad2_d = {rad2_q[RAD_W-2:0], 1'b0}
               + (m2s_q[step_q] ? RAD_W'(m2s_q) : '0)
               + (m2c_q[step_q] ? RAD_W'(m2c_q) : '0);
        if (step_q == '0) begin
          state_d = ST_ROOT;
          step_d  = LAST_STEP;
          rem1_d  = '0;
          rem2_d  = '0;
          root1_d = '0;
          root2_d = '0;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_ROOT: begin
        rad1_d = {rad1_q[RAD_W-3:0], 2'b00};
        rad2_d = {rad2_q[RAD_W-3:0], 2'b00};
        if (sh1 >= tr1) begin
          rem1_d  = sh1 - tr1;
          root1_d = {root1_q[ACC_W-2:0], 1'b1};
        end else begin
          rem1_d  = sh1;
          root1_d = {root1_q[ACC_W-2:0], 1'b0};
        end
        if (sh2 >= tr2) begin
          rem2_d  = sh2 - tr2;
          root2_d = {root2_q[ACC_W-2:0], 1'b1};
        end else begin
          rem2_d  = sh2;
          root2_d = {root2_q[ACC_W-2:0], 1'b0};
        end
        if (step_q == '0) begin
          state_d = ST_WAIT;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_WAIT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    rad1_q  <= rad1_d;
    rad2_q  <= rad2_d;
    rem1_q  <= rem1_d;
    rem2_q  <= rem2_d;
    root1_q <= root1_d;
    root2_q <= root2_d;
    if (pop_o) begin
      m1s_q <= abs_val(a1s);
      m1c_q <= abs_val(a1c);
      m2s_q <= abs_val(a2s);
      m2c_q <= abs_val(a2c);
    end
    if (load_out) begin
      str1_q <= STRENGTH_W'(root1_q);
      str2_q <= STRENGTH_W'(root2_q);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign strength_one_o = str1_q;
  assign strength_two_o = str2_q;

endmodule

`default_nettype wire

### rtl/dual_channel_tone_strength_unit.sv
// Top level of the dual channel tone strength unit.
// Instantiates dcts_front, dcts_acc_fifo and dcts_magnitude; uses dcts_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Single-bin DFT magnitude for two ADC channels. Each input item is a pair of
// samples; the accumulator takes one pair per clock (three-stage pipeline:
// table lookup, multiply, accumulate). After window_length pairs the four
// window totals move into a four-entry queue, the accumulators and phase
// restart, and the magnitude unit turns one queued set into one result:
// a serial sum of squares of ACC_W steps followed by a two-bits-a-step
// square root of ACC_W steps. Windows long enough for the magnitude unit
// to keep up run at one pair per cycle; shorter windows are paced by the
// magnitude unit once the queue fills. A result waits in the output
// register without blocking the next window. Configuration writes take
// effect at once and belong in idle periods.
module dual_channel_tone_strength_unit #(
  parameter int unsigned SAMPLE_BITS     = 12,
  parameter int unsigned TABLE_ADDR_BITS = 10
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [dcts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [dcts_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Sample stream
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [11:0] sample_one, [23:12] sample_two
  input  wire logic [dcts_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // Result stream
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // [37:0] strength_one, [75:38] strength_two, [79:76] zero
  output logic [dcts_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o
);
  import dcts_pkg::*;

  localparam int unsigned EFF_W = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int unsigned ACC_W = EFF_W + 27;

  fifo_status_t          fifo_status;
  logic                  push;
  logic [4*ACC_W-1:0]    push_data;
  logic                  pop;
  logic [4*ACC_W-1:0]    pop_data;
  logic [STRENGTH_W-1:0] strength_one;
  logic [STRENGTH_W-1:0] strength_two;

  dcts_front #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
    .ACC_W           (ACC_W)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .sample_one_i  (s_axis_tdata_i[SAMPLE_W-1:0]),
    .sample_two_i  (s_axis_tdata_i[2*SAMPLE_W-1:SAMPLE_W]),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  dcts_acc_fifo #(
    .WIDTH (4 * ACC_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (fifo_status)
  );

  dcts_magnitude #(
    .ACC_W (ACC_W)
  ) u_magnitude (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fifo_status_i  (fifo_status),
    .pop_data_i     (pop_data),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .strength_one_o (strength_one),
    .strength_two_o (strength_two)
  );

  assign m_axis_tdata_o = {{(OUT_DATA_W - 2*STRENGTH_W){1'b0}}, strength_two, strength_one};

endmodule

`default_nettype wire
